// ===== hdl/rpn_float_stack_engine_top_defines.svh =====
// assertion macros for the rpn float stack engine
// included by the top level; no other dependencies
`ifndef RPN_FLOAT_STACK_ENGINE_TOP_DEFINES_SVH
`define RPN_FLOAT_STACK_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RFSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfse check failed");
`define RFSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfse check failed");
`else
`define RFSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RFSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rfse_pkg.sv =====
// shared types and constants of the rpn float stack engine
// no dependencies
package rfse_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_DUP  = 3'd5;
    localparam logic [2:0] CMD_SWAP = 3'd6;

    // float unit sizing
    localparam int MUL_STEPS = 4;
    localparam int MUL_CHUNK = 14;
    localparam int DIV_STEPS = 56;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    // datapath operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_READ,
        DP_UNPACK,
        DP_PRENORM,
        DP_MUL_STEP,
        DP_MUL_PACK,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_PACK,
        DP_ALIGN,
        DP_SUM,
        DP_NORM,
        DP_ROUND,
        DP_COMMIT,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       skip;
        logic       special;
        logic       prenorm_done;
        logic       norm_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== hdl/rfse_dp.sv =====
// datapath: stack memory, top register, double add/mul/div unit, output word
// depends on rfse_pkg
module rfse_dp import rfse_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  dp_cmd_t     dcmd,
    output dp_stat_t    stat,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    logic [63:0] mem [STACK_DEPTH];

    logic [DW-1:0] depth_reg, depth_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   top_reg, lit_reg, rd_data_reg, res_reg;
    logic [2:0]    cmd_reg;
    logic          uf_reg, of_reg, skip_reg;
    logic          sa_reg, sb_reg, rs_reg, sub_reg, spec_reg;
    logic [63:0]   spec_val_reg;
    logic signed [13:0] ea_reg, eb_reg, re_reg;
    logic [52:0]   ma_reg, mb_reg;
    logic [56:0]   rm_reg, addend_reg;
    logic [105:0]  acc_reg;
    logic [53:0]   rem_reg;
    logic [55:0]   q_reg;
    logic [71:0]   m_tdata_reg;
    logic [1:0]    m_tuser_reg;

    // right shift that folds lost bits into bit zero
    function automatic logic [56:0] shr_sticky(input logic [56:0] v, input logic [5:0] n);
        logic [120:0] ext;
        begin
            ext = {v, 64'd0} >> n;
            return {ext[120:65], ext[64] | (|ext[63:0])};
        end
    endfunction

    // stack addresses
    logic [DW-1:0] dm1, dm2;
    logic [AW-1:0] addr_top, addr_sec;
    assign dm1 = depth_reg - DW'(1);
    assign dm2 = depth_reg - DW'(2);
    assign addr_top = dm1[AW-1:0];
    assign addr_sec = dm2[AW-1:0];

    // flags of an incoming word against the current depth
    logic in_bin, in_uf, in_of;
    assign in_bin = (s_tuser == CMD_ADD) || (s_tuser == CMD_SUB) || (s_tuser == CMD_MUL)
                 || (s_tuser == CMD_DIV) || (s_tuser == CMD_SWAP);
    assign in_uf = in_bin && (depth_reg < DW'(2));
    assign in_of = ((s_tuser == CMD_PUSH) || ((s_tuser == CMD_DUP) && (depth_reg != '0)))
                && (depth_reg == FULL);

    // operand decode
    logic [63:0] ya, xb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sxm;
    logic        spec_c;
    logic [63:0] spec_val_c;
    assign ya = rd_data_reg;
    assign xb = top_reg;
    assign a_nan  = (ya[62:52] == 11'h7FF) && (ya[51:0] != '0);
    assign b_nan  = (xb[62:52] == 11'h7FF) && (xb[51:0] != '0);
    assign a_inf  = (ya[62:52] == 11'h7FF) && (ya[51:0] == '0);
    assign b_inf  = (xb[62:52] == 11'h7FF) && (xb[51:0] == '0);
    assign a_zero = (ya[62:0] == '0);
    assign b_zero = (xb[62:0] == '0);
    assign sbe = xb[63] ^ (cmd_reg == CMD_SUB);
    assign sxm = ya[63] ^ xb[63];

    // special operands decided up front
    always_comb
    begin
        spec_c = 1'b1;
        spec_val_c = '0;
        if ((cmd_reg == CMD_DIV) && b_zero)
        begin
            spec_val_c = '0;
        end
        else if (a_nan)
        begin
            spec_val_c = ya | 64'h0008_0000_0000_0000;
        end
        else if (b_nan)
        begin
            spec_val_c = xb | 64'h0008_0000_0000_0000;
        end
        else if ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB))
        begin
            priority if (a_inf && b_inf && (ya[63] != sbe)) spec_val_c = DEFAULT_NAN;
            else if (a_inf) spec_val_c = ya;
            else if (b_inf) spec_val_c = {sbe, 11'h7FF, 52'd0};
            else spec_c = 1'b0;
        end
        else if (cmd_reg == CMD_MUL)
        begin
            priority if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val_c = DEFAULT_NAN;
            else if (a_inf || b_inf) spec_val_c = {sxm, 11'h7FF, 52'd0};
            else if (a_zero || b_zero) spec_val_c = {sxm, 63'd0};
            else spec_c = 1'b0;
        end
        else
        begin
            priority if (a_inf && b_inf) spec_val_c = DEFAULT_NAN;
            else if (a_inf) spec_val_c = {sxm, 11'h7FF, 52'd0};
            else if (b_inf || a_zero) spec_val_c = {sxm, 63'd0};
            else spec_c = 1'b0;
        end
    end

    // multiply partial product
    logic [55:0]  mb_ext;
    logic [13:0]  chunk;
    logic [66:0]  prod;
    logic [105:0] pp;
    assign mb_ext = {3'd0, mb_reg};
    assign chunk  = mb_ext[int'(dcmd.step) * MUL_CHUNK +: MUL_CHUNK];
    assign prod   = ma_reg * chunk;
    assign pp     = 106'(prod) << (int'(dcmd.step) * MUL_CHUNK);

    // divide step
    logic        div_ge;
    logic [53:0] rem_sub;
    assign div_ge  = rem_reg >= {1'b0, mb_reg};
    assign rem_sub = div_ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    // add alignment
    logic        a_big;
    logic signed [13:0] ediff;
    logic [5:0]  dsh;
    logic [56:0] fa, fb;
    assign a_big = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
    assign ediff = a_big ? (ea_reg - eb_reg) : (eb_reg - ea_reg);
    assign dsh   = (ediff > 14'sd63) ? 6'd63 : ediff[5:0];
    assign fa    = {1'b0, ma_reg, 3'd0};
    assign fb    = {1'b0, mb_reg, 3'd0};

    logic [56:0] sum_c;
    assign sum_c = sub_reg ? (rm_reg - addend_reg) : (rm_reg + addend_reg);

    // normalization step
    logic signed [13:0] den_amt;
    logic [5:0]  den_sh;
    assign den_amt = 14'sd1 - re_reg;
    assign den_sh  = (den_amt > 14'sd63) ? 6'd63 : den_amt[5:0];

    // rounding to nearest even
    logic        rnd_up, rnd_carry, rnd_ovf;
    logic [53:0] rnd_sum;
    logic [52:0] rnd_mant;
    logic signed [13:0] rnd_exp;
    logic [63:0] rounded;
    assign rnd_up    = rm_reg[2] & (rm_reg[1] | rm_reg[0] | rm_reg[3]);
    assign rnd_sum   = {1'b0, rm_reg[55:3]} + 54'(rnd_up);
    assign rnd_carry = rnd_sum[53];
    assign rnd_mant  = rnd_carry ? rnd_sum[53:1] : rnd_sum[52:0];
    assign rnd_exp   = rnd_carry ? (re_reg + 14'sd1) : re_reg;
    assign rnd_ovf   = rnd_mant[52] && (rnd_exp >= 14'sd2047);
    assign rounded   = rnd_ovf ? {rs_reg, 11'h7FF, 52'd0}
                     : {rs_reg, (rnd_mant[52] ? rnd_exp[10:0] : 11'd0), rnd_mant[51:0]};

    // stack write port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = addr_top;
        if (dcmd.op == DP_COMMIT)
        begin
            priority if (cmd_reg == CMD_PUSH) wr_en = (depth_reg != '0);
            else if (cmd_reg == CMD_DUP) wr_en = 1'b1;
            else if (cmd_reg == CMD_SWAP)
            begin
                wr_en = 1'b1;
                wr_addr = addr_sec;
            end
            else wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (dcmd.op == DP_READ)
        begin
            rd_data_reg <= mem[addr_sec];
        end
    end

    // control state: depth and output valid
    always_comb
    begin
        depth_next = depth_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (dcmd.op == DP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        if (dcmd.op == DP_COMMIT)
        begin
            if ((cmd_reg == CMD_PUSH) || (cmd_reg == CMD_DUP))
            begin
                depth_next = depth_reg + DW'(1);
            end
            else if (cmd_reg != CMD_SWAP)
            begin
                depth_next = depth_reg - DW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers per operation
    always_ff @(posedge clk)
    begin
        unique case (dcmd.op)
            DP_LOAD:
            begin
                cmd_reg  <= s_tuser;
                lit_reg  <= s_tdata;
                uf_reg   <= in_uf;
                of_reg   <= in_of;
                skip_reg <= in_uf || in_of || (s_tuser == 3'd7)
                         || ((s_tuser == CMD_DUP) && (depth_reg == '0));
            end
            DP_UNPACK:
            begin
                sa_reg <= ya[63];
                sb_reg <= sbe;
                ea_reg <= (ya[62:52] == '0) ? 14'sd1 : $signed({3'd0, ya[62:52]});
                eb_reg <= (xb[62:52] == '0) ? 14'sd1 : $signed({3'd0, xb[62:52]});
                ma_reg <= {(ya[62:52] != '0), ya[51:0]};
                mb_reg <= {(xb[62:52] != '0), xb[51:0]};
                spec_reg <= spec_c;
                spec_val_reg <= spec_val_c;
                acc_reg <= '0;
            end
            DP_PRENORM:
            begin
                if (!ma_reg[52])
                begin
                    if (ma_reg[52:45] == '0)
                    begin
                        ma_reg <= ma_reg << 8;
                        ea_reg <= ea_reg - 14'sd8;
                    end
                    else
                    begin
                        ma_reg <= ma_reg << 1;
                        ea_reg <= ea_reg - 14'sd1;
                    end
                end
                if (!mb_reg[52])
                begin
                    if (mb_reg[52:45] == '0)
                    begin
                        mb_reg <= mb_reg << 8;
                        eb_reg <= eb_reg - 14'sd8;
                    end
                    else
                    begin
                        mb_reg <= mb_reg << 1;
                        eb_reg <= eb_reg - 14'sd1;
                    end
                end
            end
            DP_MUL_STEP:
            begin
                acc_reg <= acc_reg + pp;
            end
            DP_MUL_PACK:
            begin
                rs_reg <= sa_reg ^ sb_reg;
                re_reg <= ea_reg + eb_reg - 14'sd1023;
                rm_reg <= {acc_reg[105:50], |acc_reg[49:0]};
            end
            DP_DIV_INIT:
            begin
                rem_reg <= {1'b0, ma_reg};
                q_reg <= '0;
            end
            DP_DIV_STEP:
            begin
                rem_reg <= {rem_sub[52:0], 1'b0};
                q_reg <= {q_reg[54:0], div_ge};
            end
            DP_DIV_PACK:
            begin
                rs_reg <= sa_reg ^ sb_reg;
                re_reg <= ea_reg - eb_reg + 14'sd1022;
                rm_reg <= {q_reg, (rem_reg != '0)};
            end
            DP_ALIGN:
            begin
                sub_reg <= sa_reg ^ sb_reg;
                if (a_big)
                begin
                    rs_reg <= sa_reg;
                    re_reg <= ea_reg;
                    rm_reg <= fa;
                    addend_reg <= shr_sticky(fb, dsh);
                end
                else
                begin
                    rs_reg <= sb_reg;
                    re_reg <= eb_reg;
                    rm_reg <= fb;
                    addend_reg <= shr_sticky(fa, dsh);
                end
            end
            DP_SUM:
            begin
                rm_reg <= sum_c;
                if (sum_c == '0)
                begin
                    rs_reg <= sa_reg & sb_reg;
                end
            end
            DP_NORM:
            begin
                priority if (rm_reg[56])
                begin
                    rm_reg <= {1'b0, rm_reg[56:2], rm_reg[1] | rm_reg[0]};
                    re_reg <= re_reg + 14'sd1;
                end
                else if (rm_reg == '0)
                begin
                    re_reg <= 14'sd1;
                end
                else if (re_reg < 14'sd1)
                begin
                    rm_reg <= shr_sticky(rm_reg, den_sh);
                    re_reg <= 14'sd1;
                end
                else if (!rm_reg[55] && (re_reg > 14'sd1))
                begin
                    if ((rm_reg[55:48] == '0) && (re_reg > 14'sd8))
                    begin
                        rm_reg <= rm_reg << 8;
                        re_reg <= re_reg - 14'sd8;
                    end
                    else
                    begin
                        rm_reg <= rm_reg << 1;
                        re_reg <= re_reg - 14'sd1;
                    end
                end
            end
            DP_ROUND:
            begin
                res_reg <= spec_reg ? spec_val_reg : rounded;
            end
            DP_COMMIT:
            begin
                // dup keeps the top, its copy goes to memory
                priority if (cmd_reg == CMD_PUSH) top_reg <= lit_reg;
                else if (cmd_reg == CMD_SWAP) top_reg <= rd_data_reg;
                else if (cmd_reg != CMD_DUP) top_reg <= res_reg;
                else top_reg <= top_reg;
            end
            DP_OUT:
            begin
                m_tdata_reg <= {1'b0, 7'(depth_reg), ((depth_reg != '0) ? top_reg : 64'd0)};
                m_tuser_reg <= {of_reg, uf_reg};
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    assign stat.cmd          = cmd_reg;
    assign stat.skip         = skip_reg;
    assign stat.special      = spec_reg;
    assign stat.prenorm_done = ma_reg[52] & mb_reg[52];
    assign stat.norm_done    = (rm_reg == '0) ? (re_reg == 14'sd1)
                             : (!rm_reg[56] && (re_reg >= 14'sd1)
                                && (rm_reg[55] || (re_reg == 14'sd1)));
    assign stat.out_free     = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/rfse_ctrl.sv =====
// controller: sequences one command word through the datapath
// depends on rfse_pkg
module rfse_ctrl import rfse_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  dcmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_UNPACK,
        ST_PRENORM,
        ST_MUL,
        ST_MPACK,
        ST_DINIT,
        ST_DIV,
        ST_DPACK,
        ST_ALIGN,
        ST_SUM,
        ST_NORM,
        ST_ROUND,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        dcmd.op = DP_NOP;
        dcmd.step = cnt_reg[1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dcmd.op = DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (stat.skip) state_next = ST_FINISH;
                else if ((stat.cmd == CMD_PUSH) || (stat.cmd == CMD_DUP)) state_next = ST_COMMIT;
                else state_next = ST_READ;
            end
            ST_READ:
            begin
                dcmd.op = DP_READ;
                state_next = ST_UNPACK;
            end
            ST_UNPACK:
            begin
                if (stat.cmd == CMD_SWAP)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    dcmd.op = DP_UNPACK;
                    state_next = ((stat.cmd == CMD_ADD) || (stat.cmd == CMD_SUB))
                               ? ST_ALIGN : ST_PRENORM;
                end
            end
            ST_PRENORM:
            begin
                priority if (stat.special) state_next = ST_ROUND;
                else if (stat.prenorm_done)
                begin
                    cnt_next = '0;
                    state_next = (stat.cmd == CMD_MUL) ? ST_MUL : ST_DINIT;
                end
                else dcmd.op = DP_PRENORM;
            end
            ST_MUL:
            begin
                dcmd.op = DP_MUL_STEP;
                if (cnt_reg == 6'(MUL_STEPS - 1)) state_next = ST_MPACK;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_MPACK:
            begin
                dcmd.op = DP_MUL_PACK;
                state_next = ST_NORM;
            end
            ST_DINIT:
            begin
                dcmd.op = DP_DIV_INIT;
                cnt_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dcmd.op = DP_DIV_STEP;
                if (cnt_reg == 6'(DIV_STEPS - 1)) state_next = ST_DPACK;
                else cnt_next = cnt_reg + 6'd1;
            end
            ST_DPACK:
            begin
                dcmd.op = DP_DIV_PACK;
                state_next = ST_NORM;
            end
            ST_ALIGN:
            begin
                if (stat.special)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    dcmd.op = DP_ALIGN;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                dcmd.op = DP_SUM;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (stat.norm_done) state_next = ST_ROUND;
                else dcmd.op = DP_NORM;
            end
            ST_ROUND:
            begin
                dcmd.op = DP_ROUND;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                dcmd.op = DP_COMMIT;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    dcmd.op = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== hdl/rpn_float_stack_engine_top.sv =====
// top level of the rpn float stack engine: controller plus datapath
// depends on rfse_pkg, rfse_ctrl, rfse_dp and the assertion macro header
//
//  channel  dir  tdata                          tuser
//  s_*      in   literal[63:0]                  cmd[2:0]
//  m_*      out  top_value[63:0] depth_now[70:64]  underflow[0] overflow[1]
//
// one word at a time; div finds its 56 quotient bits one a cycle, and prenormalize
// steps (mul/div) and normalize steps add to the time; special operands of add/sub/
// mul/div skip the arithmetic; the next word is taken once the result sits in the
// output register; reset leaves the stack empty; a stalled output holds the block
// in its last state
`include "rpn_float_stack_engine_top_defines.svh"
module rpn_float_stack_engine_top import rfse_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // literal
    input  logic [2:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // top_value, depth_now, zero pad
    output logic [1:0]  m_tuser    // underflow, overflow
);

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    // sequencer
    rfse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .dcmd     (dcmd)
    );

    // stack and float unit
    rfse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .dcmd     (dcmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // checks
    `RFSE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `RFSE_ASSERT_IMPL(a_flags_exclusive, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    `RFSE_ASSERT_IMPL(a_overflow_full, clk, rst_n, m_tvalid && m_tuser[1],
                      m_tdata[70:64] == 7'(STACK_DEPTH))

endmodule
